// ===== sv/g3f_pkg.sv =====
// ----------------------------------------------------------------------------
// g3f_pkg: shared types and constants of the 3x3 gray filter
// Register map, command codes, gray weights, reciprocal constants, bundles.
// ----------------------------------------------------------------------------
package g3f_pkg;

  // APB register port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [11:0] RESET_WIDTH  = 12'd640;
  localparam logic [15:0] RESET_HEIGHT = 16'd480;
  localparam int unsigned MIN_WIDTH    = 3;

  // request command codes
  localparam logic CMD_PIXEL = 1'b0;

  // Q0.16 luma weights, sum is 65536
  localparam logic [15:0] GRAY_W_R = 16'd19595;
  localparam logic [15:0] GRAY_W_G = 16'd38470;
  localparam logic [15:0] GRAY_W_B = 16'd7471;

  // ceil(2^16/9) and ceil(2^16/10): exact for sums up to 2295
  localparam logic [12:0] MEAN_RECIP  = 13'd7282;
  localparam logic [12:0] TENTH_RECIP = 13'd6554;
  localparam int unsigned RECIP_SHIFT = 16;

  localparam int unsigned WIN_CENTER = 4;

  typedef struct packed {
    logic        mode;
    logic [11:0] width;
    logic [15:0] height;
  } cfg_t;

  typedef struct packed {
    logic        border;
    logic        last;
    logic [15:0] row;
    logic [10:0] col;
  } meta_t;

  typedef struct packed {
    logic  use_pix;
    logic  emit;
    meta_t meta;
  } pix_ctl_t;

  // 3x3 window, index row*3+col, col 2 is the newest column
  typedef logic [8:0][7:0] win_t;

endpackage

// ===== sv/g3f_in_if.sv =====
// ----------------------------------------------------------------------------
// g3f_in_if: pixel request channel
// Valid/ready handshake carrying command and RGB components.
// ----------------------------------------------------------------------------
interface g3f_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, cmd, red, green, blue, input ready);
  modport sink   (input valid, cmd, red, green, blue, output ready);
endinterface

// ===== sv/g3f_out_if.sv =====
// ----------------------------------------------------------------------------
// g3f_out_if: filtered pixel channel
// Valid/ready handshake carrying gray value and its image position.
// ----------------------------------------------------------------------------
interface g3f_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  gray_out;
  logic [15:0] out_row;
  logic [10:0] out_col;
  logic        out_last;

  modport source (output valid, gray_out, out_row, out_col, out_last, input ready);
  modport sink   (input valid, gray_out, out_row, out_col, out_last, output ready);
endinterface

// ===== sv/g3f_regs.sv =====
// ----------------------------------------------------------------------------
// g3f_regs: APB configuration registers
// Mode, width and height; write strobe goes to the geometry sequencer.
// ----------------------------------------------------------------------------
module g3f_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [g3f_pkg::APB_AW-1:0]   paddr,
  input  logic [g3f_pkg::APB_DW-1:0]   pwdata,
  output logic [g3f_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output g3f_pkg::cfg_t                cfg,
  output logic                         cfg_wr
);

  logic        mode_r;
  logic [11:0] width_r;
  logic [15:0] height_r;
  logic [1:0]  reg_sel;

  assign reg_sel = paddr[3:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      width_r  <= g3f_pkg::RESET_WIDTH;
      height_r <= g3f_pkg::RESET_HEIGHT;
    end else if (cfg_wr) begin
      case (reg_sel)
        g3f_pkg::REG_MODE:   mode_r   <= pwdata[0];
        g3f_pkg::REG_WIDTH:  width_r  <= pwdata[11:0];
        g3f_pkg::REG_HEIGHT: height_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      g3f_pkg::REG_MODE:   prdata = {31'd0, mode_r};
      g3f_pkg::REG_WIDTH:  prdata = {20'd0, width_r};
      g3f_pkg::REG_HEIGHT: prdata = {16'd0, height_r};
      default:             prdata = '0;
    endcase
  end

  assign cfg.mode   = mode_r;
  assign cfg.width  = width_r;
  assign cfg.height = height_r;

endmodule

// ===== sv/g3f_ctrl.sv =====
// ----------------------------------------------------------------------------
// g3f_ctrl: raster position counters and geometry sequencer
// Tracks input and output positions; after reset or a register write it
// rebuilds the derived geometry, including a bit-serial p / W divide.
// ----------------------------------------------------------------------------
module g3f_ctrl #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  g3f_pkg::cfg_t                 cfg,
  input  logic                          cfg_wr,
  input  logic                          accept,
  input  logic                          cmd,
  output logic                          busy,
  output logic                          item_go,
  output g3f_pkg::pix_ctl_t             ctl,
  output logic [$clog2(MAX_WIDTH)-1:0]  idx
);

  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned KW    = WW + 16;
  localparam int unsigned CNT_W = $clog2(KW);

  typedef enum logic [2:0] {RC_IDLE, RC_LATCH, RC_MULT, RC_SUM, RC_DIV} rc_state_t;

  rc_state_t        state_r, state_nxt;
  logic [WW-1:0]    w_r, w_nxt;
  logic [15:0]      h_r, h_nxt;
  logic [KW-1:0]    total_r, total_nxt;
  logic [KW-1:0]    rowprod_r, rowprod_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [KW-1:0]    p_r, p_nxt;
  logic [KW-1:0]    orow_r, orow_nxt;
  logic [KW-1:0]    quo_r, quo_nxt;
  logic [WW-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [CW-1:0]    ocol_r, ocol_nxt;
  logic [15:0]      row_r, row_nxt;

  logic          in_img, is_pix, emit, last, border, col_wrap, ocol_wrap, row_sat;
  logic [WW:0]   rem_sh;
  logic          rem_ge;

  // position-derived flags for the request being taken
  assign in_img    = k_r < total_r;
  assign is_pix    = cmd == g3f_pkg::CMD_PIXEL;
  assign emit      = k_r > KW'(w_r);
  assign last      = p_r >= total_r - KW'(1);
  assign col_wrap  = WW'(col_r) >= w_r - WW'(1);
  assign ocol_wrap = WW'(ocol_r) >= w_r - WW'(1);
  assign row_sat   = row_r == 16'hFFFF;
  assign border    = (orow_r == '0) || (orow_r >= KW'(h_r) - KW'(1)) ||
                     (ocol_r == '0) || ocol_wrap;

  // drain before the image is complete is swallowed
  assign item_go = accept && !(!is_pix && in_img);
  assign busy    = state_r != RC_IDLE;

  assign ctl.use_pix     = is_pix && in_img;
  assign ctl.emit        = emit;
  assign ctl.meta.border = border;
  assign ctl.meta.last   = last;
  assign ctl.meta.row    = orow_r[15:0];
  assign ctl.meta.col    = 11'(ocol_r);
  assign idx             = col_r;

  // restoring divide step
  assign rem_sh = {rem_r, quo_r[KW-1]};
  assign rem_ge = rem_sh >= {1'b0, w_r};

  always_comb begin
    state_nxt   = state_r;
    w_nxt       = w_r;
    h_nxt       = h_r;
    total_nxt   = total_r;
    rowprod_nxt = rowprod_r;
    k_nxt       = k_r;
    p_nxt       = p_r;
    orow_nxt    = orow_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    col_nxt     = col_r;
    ocol_nxt    = ocol_r;
    row_nxt     = row_r;

    case (state_r)
      RC_IDLE: begin
        if (item_go) begin
          if (col_wrap) begin
            col_nxt = '0;
            row_nxt = row_sat ? row_r : row_r + 16'd1;
            // k = row*W + col, so row*W = k - col
            k_nxt   = k_r - KW'(col_r) + (row_sat ? '0 : KW'(w_r));
          end else begin
            col_nxt = col_r + CW'(1);
            k_nxt   = k_r + KW'(1);
          end
          if (emit) begin
            if (last) begin
              col_nxt  = '0;
              row_nxt  = '0;
              k_nxt    = '0;
              p_nxt    = '0;
              orow_nxt = '0;
              ocol_nxt = '0;
            end else begin
              p_nxt = p_r + KW'(1);
              if (ocol_wrap) begin
                ocol_nxt = '0;
                orow_nxt = orow_r + KW'(1);
              end else begin
                ocol_nxt = ocol_r + CW'(1);
              end
            end
          end
        end
      end
      RC_LATCH: begin
        if (32'(cfg.width) > MAX_WIDTH) begin
          w_nxt = WW'(MAX_WIDTH);
        end else if (cfg.width < 12'(g3f_pkg::MIN_WIDTH)) begin
          w_nxt = WW'(g3f_pkg::MIN_WIDTH);
        end else begin
          w_nxt = WW'(cfg.width);
        end
        h_nxt     = (cfg.height == 16'd0) ? 16'd1 : cfg.height;
        state_nxt = RC_MULT;
      end
      RC_MULT: begin
        total_nxt   = KW'(w_r) * KW'(h_r);
        rowprod_nxt = KW'(row_r) * KW'(w_r);
        state_nxt   = RC_SUM;
      end
      RC_SUM: begin
        k_nxt     = rowprod_r + KW'(col_r);
        quo_nxt   = p_r;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = RC_DIV;
      end
      RC_DIV: begin
        rem_nxt = rem_ge ? WW'(rem_sh - {1'b0, w_r}) : WW'(rem_sh);
        quo_nxt = {quo_r[KW-2:0], rem_ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(KW - 1)) begin
          orow_nxt  = quo_nxt;
          ocol_nxt  = CW'(rem_nxt);
          state_nxt = RC_IDLE;
        end
      end
      default: state_nxt = RC_LATCH;
    endcase

    if (cfg_wr) begin
      state_nxt = RC_LATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RC_LATCH;
      col_r   <= '0;
      row_r   <= '0;
      k_r     <= '0;
      p_r     <= '0;
      orow_r  <= '0;
      ocol_r  <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      k_r     <= k_nxt;
      p_r     <= p_nxt;
      orow_r  <= orow_nxt;
      ocol_r  <= ocol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r       <= w_nxt;
    h_r       <= h_nxt;
    total_r   <= total_nxt;
    rowprod_r <= rowprod_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
  end

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != RC_IDLE) |-> !accept)
    else $error("request taken during geometry rebuild");

  a_ocol_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == RC_IDLE) |-> (WW'(ocol_r) < w_r))
    else $error("output column outside row width");

  a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (item_go && emit && last) |=> (k_r == '0 && p_r == '0 && col_r == '0))
    else $error("counters not rewound after last pixel");

endmodule

// ===== sv/g3f_window.sv =====
// ----------------------------------------------------------------------------
// g3f_window: gray conversion, two line stores and the 3x3 window
// Stage 1 holds the request and line store reads, stage 2 the window.
// ----------------------------------------------------------------------------
module g3f_window #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_load,
  input  g3f_pkg::pix_ctl_t             ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0]  idx,
  input  logic [7:0]                    red,
  input  logic [7:0]                    green,
  input  logic [7:0]                    blue,
  input  logic                          s2_take,
  output logic                          s1_ready,
  output logic                          v2,
  output g3f_pkg::meta_t                meta2,
  output g3f_pkg::win_t                 win
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic [7:0]        upper_mem  [MAX_WIDTH];
  logic [7:0]        middle_mem [MAX_WIDTH];

  logic              v1_r, v2_r;
  g3f_pkg::pix_ctl_t ctl1_r;
  logic [CW-1:0]     idx1_r;
  logic [7:0]        red1_r, green1_r, blue1_r;
  logic [7:0]        rdu_r, rdm_r;
  g3f_pkg::meta_t    meta2_r;
  g3f_pkg::win_t     win_r, win_nxt;

  logic              en1, en2, pass;
  logic [23:0]       acc;
  logic [7:0]        gray;

  assign en2      = !v2_r || s2_take;
  assign en1      = !v1_r || en2;
  assign pass     = v1_r && en2;
  assign s1_ready = en1;

  assign acc  = 24'(red1_r) * 24'(g3f_pkg::GRAY_W_R)
              + 24'(green1_r) * 24'(g3f_pkg::GRAY_W_G)
              + 24'(blue1_r) * 24'(g3f_pkg::GRAY_W_B);
  // drains and pixels past the image shift in zero
  assign gray = ctl1_r.use_pix ? acc[23:16] : 8'd0;

  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = rdu_r;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = rdm_r;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = gray;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      win_r <= '0;
    end else begin
      if (en1) v1_r <= s1_load;
      if (en2) v2_r <= v1_r && ctl1_r.emit;
      if (pass) win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      ctl1_r   <= ctl;
      idx1_r   <= idx;
      red1_r   <= red;
      green1_r <= green;
      blue1_r  <= blue;
    end
    if (pass) meta2_r <= ctl1_r.meta;
  end

  // line stores: read on take, write back as the item leaves stage 1
  always_ff @(posedge clk) begin
    if (s1_load) begin
      rdu_r <= upper_mem[idx];
      rdm_r <= middle_mem[idx];
    end
    if (pass) begin
      upper_mem[idx1_r]  <= rdm_r;
      middle_mem[idx1_r] <= gray;
    end
  end

  assign v2    = v2_r;
  assign meta2 = meta2_r;
  assign win   = win_r;

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !s2_take) |=> (v2_r && $stable(meta2_r) && $stable(win_r)))
    else $error("stalled window item changed");

endmodule

// ===== sv/g3f_kernel.sv =====
// ----------------------------------------------------------------------------
// g3f_kernel: window arithmetic and output register
// Stage 3 sums the window, stage 4 divides by reciprocal and selects.
// ----------------------------------------------------------------------------
module g3f_kernel (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              mode,
  input  logic              v2,
  input  g3f_pkg::meta_t    meta2,
  input  g3f_pkg::win_t     win,
  output logic              s2_take,
  g3f_out_if.source         out_ch
);

  logic           v3_r, out_valid_r;
  logic [11:0]    sum_r, alap_r;
  logic [7:0]     c_r;
  g3f_pkg::meta_t meta3_r;
  logic [7:0]     gray_r;
  logic [15:0]    row_r;
  logic [10:0]    col_r;
  logic           last_r;

  logic           en3, en4;
  logic [11:0]    sum9, nine_c, alap;
  logic [7:0]     c;
  logic [24:0]    mean_prod, tenth_prod;
  logic [8:0]     sharp;
  logic [7:0]     sharp_sat, result;

  assign en4     = !out_valid_r || out_ch.ready;
  assign en3     = !v3_r || en4;
  assign s2_take = en3;

  always_comb begin
    sum9 = '0;
    for (int i = 0; i < 9; i++) begin
      sum9 = sum9 + 12'(win[i]);
    end
  end

  assign c      = win[g3f_pkg::WIN_CENTER];
  assign nine_c = {1'b0, c, 3'b000} + 12'(c);
  // |sum of neighbours - 8*centre|
  assign alap   = (sum9 >= nine_c) ? (sum9 - nine_c) : (nine_c - sum9);

  assign mean_prod  = 25'(sum_r) * 25'(g3f_pkg::MEAN_RECIP);
  assign tenth_prod = 25'(alap_r) * 25'(g3f_pkg::TENTH_RECIP);
  assign sharp      = 9'(c_r) + 9'(tenth_prod[g3f_pkg::RECIP_SHIFT +: 8]);
  assign sharp_sat  = sharp[8] ? 8'hFF : sharp[7:0];

  always_comb begin
    if (meta3_r.border) begin
      result = c_r;
    end else if (mode) begin
      result = sharp_sat;
    end else begin
      result = mean_prod[g3f_pkg::RECIP_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en3) v3_r <= v2;
      if (en4) out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      sum_r   <= sum9;
      alap_r  <= alap;
      c_r     <= c;
      meta3_r <= meta2;
    end
    if (en4 && v3_r) begin
      gray_r <= result;
      row_r  <= meta3_r.row;
      col_r  <= meta3_r.col;
      last_r <= meta3_r.last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.gray_out = gray_r;
  assign out_ch.out_row  = row_r;
  assign out_ch.out_col  = col_r;
  assign out_ch.out_last = last_r;

  a_s3_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !en4) |=> (v3_r && $stable(sum_r) && $stable(alap_r)))
    else $error("stalled sum stage changed");

endmodule

// ===== sv/gray_3x3_mean_or_sharpen_filter.sv =====
// ----------------------------------------------------------------------------
// gray_3x3_mean_or_sharpen_filter: RGB to gray, 3x3 mean or Laplacian sharpen
// Pipeline: a result passes request/line store read, window, sum and output
//   register after the request that completes its window.
// Throughput: one request per clock unless the output stalls or a rebuild runs;
//   set by the single line store port pair. Reset: registers to defaults,
//   counters zero; the geometry rebuild holds ready low, as after writes.
// ----------------------------------------------------------------------------
module gray_3x3_mean_or_sharpen_filter #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                        clk,
  input  logic                        rst_n,
  g3f_in_if.sink                      in_ch,
  g3f_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [g3f_pkg::APB_AW-1:0]  paddr,
  input  logic [g3f_pkg::APB_DW-1:0]  pwdata,
  output logic [g3f_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  g3f_pkg::cfg_t     cfg;
  logic              cfg_wr;
  logic              busy;
  logic              accept;
  logic              item_go;
  logic              s1_ready;
  logic              s2_take;
  logic              v2;
  g3f_pkg::pix_ctl_t ctl;
  g3f_pkg::meta_t    meta2;
  g3f_pkg::win_t     win;
  logic [CW-1:0]     idx;

  // Ready follows the stage 1 enable, chained back from the output ready, and the
  // rebuild sequencer; only empty stages absorb a stall on the far side.
  assign in_ch.ready = s1_ready && !busy;
  assign accept      = in_ch.valid && in_ch.ready;

  g3f_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  // Position counters: decides per request whether it shifts the window,
  // whether it releases a result, and where that result lies.
  g3f_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr),
    .accept  (accept),
    .cmd     (in_ch.cmd),
    .busy    (busy),
    .item_go (item_go),
    .ctl     (ctl),
    .idx     (idx)
  );

  // Gray conversion, line stores and the sliding window.
  g3f_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_load  (item_go),
    .ctl      (ctl),
    .idx      (idx),
    .red      (in_ch.red),
    .green    (in_ch.green),
    .blue     (in_ch.blue),
    .s2_take  (s2_take),
    .s1_ready (s1_ready),
    .v2       (v2),
    .meta2    (meta2),
    .win      (win)
  );

  // Mean or sharpen, border pass-through, output register.
  g3f_kernel u_kernel (
    .clk     (clk),
    .rst_n   (rst_n),
    .mode    (cfg.mode),
    .v2      (v2),
    .meta2   (meta2),
    .win     (win),
    .s2_take (s2_take),
    .out_ch  (out_ch)
  );

endmodule
